>>> rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int MAX_RESULTS      = 16;   // results one drain may produce
   localparam int RANK_W           = 8;
   localparam int TAG_W            = 32;
   localparam int COUNT_W          = 5;
   localparam int OCC_W            = 5;
   localparam int STEP_W           = $clog2(MAX_RESULTS + 1);
   localparam int DATA_W           = 48;   // payload bits, rounded up to bytes

   typedef enum logic [1:0] {
      OP_INSERT      = 2'd0,
      OP_DRAIN_RANK  = 2'd1,
      OP_DRAIN_COUNT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch;     // capture the accepted request
      logic       insert;    // place the captured entry
      logic       pop;       // remove the head entry
      logic       load_out;  // write the result register
      status_type status;
      logic       last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   cont;        // a drain removes the head now
      logic   cont_after;  // and would remove the next one too
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives spq_dp through cmd_type / sts_type.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire spq_pkg::sts_type sts,
   output spq_pkg::cmd_type      cmd
);
   import spq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = ST_NONE;
      req_tready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               case (sts.op)
                  OP_INSERT: begin
                     cmd.last = 1'b1;
                     state_in = S_IDLE;
                     if (sts.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.status = ST_INSERTED;
                        cmd.insert = 1'b1;
                     end
                  end
                  default: begin
                     // drains and the unused code; the latter never continues
                     if (sts.cont) begin
                        cmd.pop    = 1'b1;
                        cmd.status = ST_REMOVED;
                        cmd.last   = !sts.cont_after;
                        if (!sts.cont_after) begin
                           state_in = S_IDLE;
                        end
                     end else begin
                        cmd.status = ST_NONE;
                        cmd.last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/spq_dp.sv
// Datapath for the sorted priority queue: entry registers, fill count,
// captured request and result register. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_dp #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [1:0]                    req_operation,
   input  wire  [spq_pkg::RANK_W-1:0]    req_rank,
   input  wire  [spq_pkg::TAG_W-1:0]     req_tag,
   input  wire  [spq_pkg::COUNT_W-1:0]   req_count,
   input  wire  spq_pkg::cmd_type        cmd,
   output spq_pkg::sts_type              sts,
   output logic [1:0]                    rsp_status,
   output logic [spq_pkg::RANK_W-1:0]    rsp_out_rank,
   output logic [spq_pkg::TAG_W-1:0]     rsp_out_tag,
   output logic                          rsp_last,
   output logic [spq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import spq_pkg::*;

   localparam int FILL_W = $clog2(CAPACITY + 1);

   logic [RANK_W-1:0]  rank_ff [CAPACITY];
   logic [RANK_W-1:0]  rank_in [CAPACITY];
   logic [TAG_W-1:0]   tag_ff  [CAPACITY];
   logic [TAG_W-1:0]   tag_in  [CAPACITY];
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [CAPACITY-1:0] lt;    // held entry ranks ahead of the new one

   op_type             op_ff;
   logic [RANK_W-1:0]  thr_ff;
   logic [TAG_W-1:0]   new_tag_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [STEP_W-1:0]  step_ff, step_in, step_next;

   status_type         out_status_ff;
   logic [RANK_W-1:0]  out_rank_ff;
   logic [TAG_W-1:0]   out_tag_ff;
   logic               out_last_ff;
   logic [OCC_W-1:0]   out_occ_ff;

   logic head_ok, head_cmp, second_cmp;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      tag_ff  <= tag_in;
      step_ff <= step_in;
      if (cmd.latch) begin
         op_ff      <= op_type'(req_operation);
         thr_ff     <= req_rank;
         new_tag_ff <= req_tag;
         count_ff   <= req_count;
      end
      if (cmd.load_out) begin
         out_status_ff <= cmd.status;
         out_last_ff   <= cmd.last;
         out_rank_ff   <= cmd.pop ? rank_ff[0] : '0;
         out_tag_ff    <= cmd.pop ? tag_ff[0] : '0;
         out_occ_ff    <= OCC_W'(fill_in);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt[i] = (FILL_W'(i) < fill_ff) && (rank_ff[i] < thr_ff);
      end
   end

   // entry update: parallel compare-and-shift insert, shift-down pop
   always_comb begin
      rank_in = rank_ff;
      tag_in  = tag_ff;
      fill_in = fill_ff;
      if (cmd.insert) begin
         if (!lt[0]) begin
            rank_in[0] = thr_ff;
            tag_in[0]  = new_tag_ff;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (lt[i-1] && !lt[i]) begin
               rank_in[i] = thr_ff;
               tag_in[i]  = new_tag_ff;
            end else if (!lt[i-1]) begin
               rank_in[i] = rank_ff[i-1];
               tag_in[i]  = tag_ff[i-1];
            end
         end
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.pop) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            rank_in[i] = rank_ff[i+1];
            tag_in[i]  = tag_ff[i+1];
         end
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_comb begin
      step_next = step_ff + STEP_W'(1);
      if (cmd.latch) begin
         step_in = '0;
      end else if (cmd.pop) begin
         step_in = step_next;
      end else begin
         step_in = step_ff;
      end
   end

   assign head_ok = (fill_ff != '0);

   always_comb begin
      case (op_ff)
         OP_DRAIN_RANK: begin
            head_cmp   = (rank_ff[0] <= thr_ff);
            second_cmp = (rank_ff[1] <= thr_ff);
         end
         OP_DRAIN_COUNT: begin
            head_cmp   = (STEP_W'(count_ff) > step_ff);
            second_cmp = (STEP_W'(count_ff) > step_next);
         end
         default: begin
            head_cmp   = 1'b0;
            second_cmp = 1'b0;
         end
      endcase
   end

   assign sts.op         = op_ff;
   assign sts.full       = (fill_ff == FILL_W'(CAPACITY));
   assign sts.cont       = head_ok && head_cmp && (step_ff < STEP_W'(MAX_RESULTS));
   assign sts.cont_after = (fill_ff > FILL_W'(1)) && second_cmp
                           && (step_next < STEP_W'(MAX_RESULTS));

   assign rsp_status    = out_status_ff;
   assign rsp_out_rank  = out_rank_ff;
   assign rsp_out_tag   = out_tag_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_occupancy = out_occ_ff;

endmodule

`default_nettype wire

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: stream ports, controller and
// datapath. Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Bounded priority queue of CAPACITY entries (rank, tag), kept sorted with
// rank 0 at the head; among equal ranks the newest entry sits first. Each
// request is an insert, a drain of all head entries with rank up to a
// threshold, or a drain of a given count of head entries. Every request
// answers with at least one response; the final response of a request has
// tlast set. A drain answers with one "removed" response per entry (at most
// 16 per request, stopping when the queue empties) or, if nothing left the
// queue, a single "nothing removed" response, as does the unused operation
// code; an insert into a full queue is answered "full" and changes nothing.
// Timing: a request is taken in the idle state, then the execute state
// emits one response per cycle unless a waiting response is stalled by
// rsp_tready; each removal shifts all entries down by one. Insert is a
// parallel compare and shift over all entries. The response register lets
// a new request be taken while the last response still waits. No clearing
// pass after reset: entries past the fill count are never read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY   // 2 .. 31
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [spq_pkg::DATA_W-1:0]   req_tdata,  // rank[7:0], tag[39:8], count[44:40]
   input  wire  [1:0]                   req_tuser,  // operation[1:0]
   // response channel
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [spq_pkg::DATA_W-1:0]   rsp_tdata,  // out_rank[7:0], out_tag[39:8],
                                                    // occupancy[44:40]
   output logic [1:0]                   rsp_tuser,  // status[1:0]
   output logic                         rsp_tlast   // last
);
   import spq_pkg::*;

   localparam int PAD_W = DATA_W - RANK_W - TAG_W - OCC_W;

   cmd_type            cmd;
   sts_type            sts;
   logic [RANK_W-1:0]  rsp_out_rank;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic [OCC_W-1:0]   rsp_occupancy;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   spq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_tuser),
      .req_rank      (req_tdata[RANK_W-1:0]),
      .req_tag       (req_tdata[RANK_W+TAG_W-1:RANK_W]),
      .req_count     (req_tdata[RANK_W+TAG_W+COUNT_W-1:RANK_W+TAG_W]),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_status    (rsp_tuser),
      .rsp_out_rank  (rsp_out_rank),
      .rsp_out_tag   (rsp_out_tag),
      .rsp_last      (rsp_tlast),
      .rsp_occupancy (rsp_occupancy)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_occupancy, rsp_out_tag, rsp_out_rank};

endmodule

`default_nettype wire

>>> rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_checker #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_tvalid,
   input wire                        req_tready,
   input wire                        rsp_tvalid,
   input wire                        rsp_tready,
   input wire [spq_pkg::DATA_W-1:0]  rsp_tdata,
   input wire [1:0]                  rsp_tuser,
   input wire                        rsp_tlast
);
   import spq_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // the block is busy in the cycle after it takes a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken twice in a row");

   // only removals can be followed by further responses of the same request
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_REMOVED |-> rsp_tlast)
      else $error("non-removal response without last");

   // non-removal responses carry no entry
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_REMOVED |-> rsp_tdata[RANK_W+TAG_W-1:0] == '0)
      else $error("entry fields set on non-removal response");

   // a full rejection reports a full queue
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL
         |-> rsp_tdata[RANK_W+TAG_W+OCC_W-1:RANK_W+TAG_W] == OCC_W'(CAPACITY))
      else $error("full response with wrong occupancy");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

`default_nettype wire
